[sv/tlvc_pkg.sv]
// tlvc_pkg: shared types and constants of the tlv change compactor
// no dependencies

package tlvc_pkg;

    localparam logic [1:0] PH_CMD  = 2'd0;
    localparam logic [1:0] PH_TYPE = 2'd1;
    localparam logic [1:0] PH_LEN  = 2'd2;
    localparam logic [1:0] PH_VAL  = 2'd3;

    // one job from the front part to the back part
    typedef struct packed {
        logic       emit;      // emit one plain byte
        logic       burst;     // emit type, length and buffered bytes
        logic [7:0] data;      // byte to emit, or type for a burst
        logic [7:0] length;    // element length for a burst
        logic       pend;      // packet end flag
        logic       over;      // oversize flag
    } t_job;

endpackage

[sv/tlvc_front.sv]
// tlvc_front: parses packet bytes, keeps the length and value stores,
// decides forwarding and writes the element buffer; uses tlvc_pkg

module tlvc_front #(
    parameter int MAX_VALUE_BYTES = 62,
    parameter int NUM_TYPES       = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_byte,
    input  logic                          i_force,
    output logic                          o_job_valid,
    input  logic                          i_job_ready,
    output tlvc_pkg::t_job                o_job,
    output logic                          o_buf_we,
    output logic [$clog2(MAX_VALUE_BYTES+1)-1:0] o_buf_addr,
    output logic [7:0]                    o_buf_data,
    input  logic                          i_back_busy
);
    import tlvc_pkg::*;

    localparam int TW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam int BW = $clog2(MAX_VALUE_BYTES + 1);
    localparam int VD = NUM_TYPES * MAX_VALUE_BYTES;
    localparam int VW = $clog2(VD);
    localparam int MVW = $clog2(MAX_VALUE_BYTES);
    localparam int MW = (MVW > 0) ? MVW : 1;

    // clear sweep: walks all NUM_TYPES length store entries after reset
    logic [TW:0]  r_clr;
    logic         r_clr_busy;
    logic [5:0]   length_store [NUM_TYPES];
    logic [7:0]   value_store  [VD];

    logic [1:0]   r_phase;
    logic [7:0]   r_type, r_len, r_cnt;
    logic         r_diff;
    // per item: stage 0 accepts and reads store, stage 1 decides
    logic         r_st;
    logic [7:0]   r_b;
    logic         r_f;
    logic [5:0]   r_ls;
    logic [7:0]   r_vs;
    logic         r_oob;

    logic         acc;
    logic         wr_go;
    t_job         job;
    logic         jv;
    logic [7:0]   cnt1;

    assign o_ready = i_rst_n && !r_clr_busy && !r_st && !o_job_valid && !i_back_busy;
    assign acc = i_valid && o_ready;

    // store reads
    logic [TW-1:0] t_idx;
    logic [MW-1:0] c_idx;
    assign t_idx = r_type[TW-1:0];
    assign c_idx = r_cnt[MW-1:0];
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_ls <= length_store[t_idx];
            r_vs <= value_store[VW'(t_idx) * VW'(MAX_VALUE_BYTES) + VW'(c_idx)];
        end
    end

    assign cnt1 = r_cnt + 8'd1;

    always_comb begin
        job = '0;
        jv = 1'b0;
        wr_go = 1'b0;
        unique case (r_phase)
            PH_CMD: begin
                jv = 1'b1; job.emit = 1'b1; job.data = r_b;
            end
            PH_TYPE: begin
                if (r_b == 8'd0) begin
                    jv = 1'b1; job.emit = 1'b1; job.pend = 1'b1;
                end
            end
            PH_LEN: begin
                if (r_b > 8'(MAX_VALUE_BYTES)) begin
                    jv = 1'b1; job.emit = 1'b1; job.over = 1'b1; job.data = r_type;
                end else if (r_b == 8'd0 &&
                             (r_f || r_oob || r_ls != 6'd0)) begin
                    jv = 1'b1; job.burst = 1'b1; job.data = r_type;
                    wr_go = !r_oob;
                end
            end
            default: begin
                if (r_len <= 8'(MAX_VALUE_BYTES) && cnt1 >= r_len &&
                    (r_diff || r_f || r_oob || r_vs != r_b)) begin
                    jv = 1'b1; job.burst = 1'b1; job.data = r_type;
                    job.length = r_len; wr_go = !r_oob;
                end
            end
        endcase
    end

    assign o_buf_we   = r_st && r_phase == PH_VAL && r_len <= 8'(MAX_VALUE_BYTES)
                        && r_cnt < 8'(MAX_VALUE_BYTES);
    assign o_buf_addr = r_cnt[BW-1:0];
    assign o_buf_data = r_b;

    // value store update: each value byte is written
    // to the store only when the element is forwarded, via a shadow write list
    // kept here as a per-element scratch of the new bytes
    logic [7:0]   scratch [MAX_VALUE_BYTES];
    logic [BW-1:0] r_cp;
    logic         r_cp_busy;
    logic [TW-1:0] r_cp_t;
    logic [7:0]   r_cp_len;
    logic         r_cw;
    logic [VW-1:0] r_cw_a;
    logic [7:0]   r_cw_d;

    always_ff @(posedge i_clk) begin
        if (o_buf_we) scratch[r_cnt[MW-1:0]] <= r_b;
        r_cw_d <= scratch[r_cp[MW-1:0]];
        r_cw_a <= VW'(r_cp_t) * VW'(MAX_VALUE_BYTES) + VW'(r_cp[MW-1:0]);
        if (r_cw)
            value_store[r_cw_a] <= r_cw_d;
        if (!i_rst_n || r_clr_busy)
            length_store[r_clr[TW-1:0]] <= 6'd0;
        else if (r_st && wr_go)
            length_store[t_idx] <= (r_phase == PH_LEN) ? 6'd0 : r_len[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0; r_clr_busy <= 1'b1;
            r_phase <= PH_CMD; r_type <= '0; r_len <= '0; r_cnt <= '0;
            r_diff <= 1'b0; r_st <= 1'b0; o_job_valid <= 1'b0;
            r_cp_busy <= 1'b0; r_cp <= '0; r_oob <= 1'b0; r_cw <= 1'b0;
        end else begin
            r_cw <= r_cp_busy;
            if (r_clr_busy) begin
                r_clr <= r_clr + 1'b1;
                if (r_clr == (TW+1)'(NUM_TYPES - 1)) r_clr_busy <= 1'b0;
            end
            if (o_job_valid && i_job_ready) o_job_valid <= 1'b0;
            if (r_cp_busy) begin
                r_cp <= r_cp + 1'b1;
                if (r_cp + 1'b1 >= r_cp_len[BW-1:0]) r_cp_busy <= 1'b0;
            end
            if (acc) begin
                r_b <= i_byte; r_f <= i_force; r_st <= 1'b1;
                r_oob <= (r_type >= 8'(NUM_TYPES - 1) + 8'd1) && (NUM_TYPES < 256);
            end
            if (r_st) begin
                r_st <= 1'b0;
                if (jv) begin
                    o_job_valid <= 1'b1; o_job <= job;
                end
                if (wr_go && r_phase == PH_VAL) begin
                    r_cp_busy <= 1'b1; r_cp <= '0; r_cp_t <= t_idx; r_cp_len <= r_len;
                end
                unique case (r_phase)
                    PH_CMD:  r_phase <= PH_TYPE;
                    PH_TYPE: begin
                        if (r_b == 8'd0) r_phase <= PH_CMD;
                        else begin r_type <= r_b; r_phase <= PH_LEN; end
                    end
                    PH_LEN: begin
                        r_len <= r_b; r_cnt <= '0;
                        r_diff <= (r_b <= 8'(MAX_VALUE_BYTES)) &&
                                  (r_f || r_oob || r_ls != r_b[5:0] || r_b[7:6] != 2'd0);
                        r_phase <= (r_b == 8'd0) ? PH_TYPE : PH_VAL;
                    end
                    default: begin
                        if (r_len <= 8'(MAX_VALUE_BYTES) && r_cnt < 8'(MAX_VALUE_BYTES)
                            && (r_f || r_oob || r_vs != r_b)) r_diff <= 1'b1;
                        r_cnt <= cnt1;
                        if (cnt1 >= r_len) r_phase <= PH_TYPE;
                    end
                endcase
            end
        end
    end
endmodule

[sv/tlvc_back.sv]
// tlvc_back: turns jobs into output beats, bursting buffered elements
// uses tlvc_pkg

module tlvc_back #(
    parameter int MAX_VALUE_BYTES = 62
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_valid,
    output logic            o_job_ready,
    input  tlvc_pkg::t_job  i_job,
    input  logic            i_buf_we,
    input  logic [$clog2(MAX_VALUE_BYTES+1)-1:0] i_buf_addr,
    input  logic [7:0]      i_buf_data,
    output logic            o_busy,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_byte,
    output logic [2:0]      o_user
);
    import tlvc_pkg::*;

    localparam int BW = $clog2(MAX_VALUE_BYTES + 1);
    localparam int MVW = $clog2(MAX_VALUE_BYTES);
    localparam int MW = (MVW > 0) ? MVW : 1;

    logic [7:0] buffer [MAX_VALUE_BYTES];
    logic [1:0] r_sel;       // 0 type, 1 length, 2 values
    logic       r_act;
    t_job       r_job;
    logic [BW-1:0] r_i;

    always_ff @(posedge i_clk) begin
        if (i_buf_we) buffer[i_buf_addr[MW-1:0]] <= i_buf_data;
    end

    assign o_job_ready = !r_act;
    assign o_busy = r_act;
    logic adv;
    assign adv = !o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0; o_valid <= 1'b0; r_sel <= '0; r_i <= '0;
        end else begin
            if (o_valid && i_ready) o_valid <= 1'b0;
            if (!r_act && i_job_valid) begin
                r_act <= 1'b1; r_job <= i_job; r_sel <= 2'd0; r_i <= '0;
            end else if (r_act && adv) begin
                o_valid <= 1'b1;
                if (r_job.emit) begin
                    o_byte <= r_job.data;
                    o_user <= {r_job.over, r_job.pend, 1'b1};
                    r_act <= 1'b0;
                end else begin
                    unique case (r_sel)
                        2'd0: begin
                            o_byte <= r_job.data; o_user <= 3'd0; r_sel <= 2'd1;
                        end
                        2'd1: begin
                            o_byte <= r_job.length;
                            o_user <= {2'd0, r_job.length == 8'd0};
                            r_sel <= 2'd2;
                            if (r_job.length == 8'd0) r_act <= 1'b0;
                        end
                        default: begin
                            o_byte <= buffer[r_i[MW-1:0]];
                            o_user <= {2'd0, 8'(r_i) + 8'd1 >= r_job.length};
                            r_i <= r_i + 1'b1;
                            if (8'(r_i) + 8'd1 >= r_job.length) r_act <= 1'b0;
                        end
                    endcase
                end
            end
        end
    end
endmodule

[sv/tlv_change_compactor_unit.sv]
// tlv_change_compactor_unit: top level of the tlv change compactor
// uses tlvc_pkg, tlvc_front and tlvc_back
// A byte is taken only once the previous one has been decided and while no
// result is pending; a byte that yields results holds the input until the
// back part has loaded its last beat into the output register, and a
// forwarded element of n value bytes gives 2 + n beats. After reset a clearing
// pass over all NUM_TYPES entries empties the length store before the first
// byte is taken.

module tlv_change_compactor_unit #(
    parameter int MAX_VALUE_BYTES = 62,
    parameter int NUM_TYPES       = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte
    input  logic        s_axis_tuser,   // force_all
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte
    output logic        m_axis_tlast,   // last_of_run
    output logic [1:0]  m_axis_tuser    // packet_end, oversize
);
    import tlvc_pkg::*;

    localparam int BW = $clog2(MAX_VALUE_BYTES + 1);

    logic          job_valid, job_ready, we, busy;
    t_job          job;
    logic [BW-1:0] addr;
    logic [7:0]    wdata;
    logic [2:0]    user;

    tlvc_front #(.MAX_VALUE_BYTES(MAX_VALUE_BYTES), .NUM_TYPES(NUM_TYPES)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_byte(s_axis_tdata), .i_force(s_axis_tuser),
        .o_job_valid(job_valid), .i_job_ready(job_ready), .o_job(job),
        .o_buf_we(we), .o_buf_addr(addr), .o_buf_data(wdata), .i_back_busy(busy)
    );

    tlvc_back #(.MAX_VALUE_BYTES(MAX_VALUE_BYTES)) u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(job_valid), .o_job_ready(job_ready), .i_job(job),
        .i_buf_we(we), .i_buf_addr(addr), .i_buf_data(wdata), .o_busy(busy),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_byte(m_axis_tdata), .o_user(user)
    );

    assign m_axis_tlast = user[0];
    assign m_axis_tuser = user[2:1];
endmodule

[bench/tlv_change_compactor_unit_test.sv]
// tlv_change_compactor_unit_test: self-checking bench for the tlv change compactor
// depends on tlvc_pkg and tlv_change_compactor_unit; packets of random elements,
// predicted byte by byte and compared beat by beat at the master side
`timescale 1ns / 100ps

module tlv_change_compactor_unit_test;
    import tlvc_pkg::*;

    localparam int MAX_VB = 62;
    localparam int N_TYPES = 256;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       pend;
        logic       over;
    } t_out_beat;

    int errors = 0;

    task automatic report(input string what);
        errors++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    class tlv_scoreboard;
        logic [1:0] ph;
        logic [7:0] cur_type;
        logic [7:0] cur_len;
        logic [7:0] count;
        bit         changed;
        logic [5:0] len_store [N_TYPES];
        logic [7:0] val_store [N_TYPES][MAX_VB];
        logic [7:0] elem_buf [MAX_VB];
        t_out_beat  expected [$];

        function new();
            ph = PH_CMD;
            cur_type = '0;
            cur_len = '0;
            count = '0;
            changed = 1'b0;
            foreach (len_store[t]) len_store[t] = '0;
            foreach (val_store[t, i]) val_store[t][i] = '0;
            foreach (elem_buf[i]) elem_buf[i] = '0;
        endfunction

        function void push(logic [7:0] d, bit pe, bit ov);
            t_out_beat b;
            b.data = d;
            b.last = 1'b0;
            b.pend = pe;
            b.over = ov;
            expected.push_back(b);
        endfunction

        function void close_element();
            if (!changed) return;
            len_store[cur_type] = cur_len[5:0];
            for (int i = 0; i < cur_len && i < MAX_VB; i++)
                val_store[cur_type][i] = elem_buf[i];
            push(cur_type, 1'b0, 1'b0);
            push(cur_len, 1'b0, 1'b0);
            for (int i = 0; i < cur_len && i < MAX_VB; i++)
                push(elem_buf[i], 1'b0, 1'b0);
        endfunction

        function void note_input(logic [7:0] b, bit frc);
            int n0;
            n0 = expected.size();
            case (ph)
                PH_CMD: begin
                    push(b, 1'b0, 1'b0);
                    ph = PH_TYPE;
                end
                PH_TYPE: begin
                    if (b == 8'd0) begin
                        push(8'd0, 1'b1, 1'b0);
                        ph = PH_CMD;
                    end else begin
                        cur_type = b;
                        ph = PH_LEN;
                    end
                end
                PH_LEN: begin
                    cur_len = b;
                    count = '0;
                    if (b > MAX_VB) begin
                        push(cur_type, 1'b0, 1'b1);
                        changed = 1'b0;
                        ph = PH_VAL;
                    end else begin
                        changed = frc || ({2'b00, len_store[cur_type]} != b);
                        if (b == 8'd0) begin
                            close_element();
                            ph = PH_TYPE;
                        end else begin
                            ph = PH_VAL;
                        end
                    end
                end
                default: begin
                    if (cur_len > MAX_VB) begin
                        count = count + 8'd1;
                        if (count >= cur_len) ph = PH_TYPE;
                    end else begin
                        if (count < MAX_VB) begin
                            elem_buf[count] = b;
                            if (frc) changed = 1'b1;
                            if (!changed && val_store[cur_type][count] != b) changed = 1'b1;
                        end
                        count = count + 8'd1;
                        if (count >= cur_len) begin
                            close_element();
                            ph = PH_TYPE;
                        end
                    end
                end
            endcase
            if (expected.size() > n0) expected[expected.size() - 1].last = 1'b1;
        endfunction

        task check_result(logic [7:0] d, logic lst, logic pe, logic ov);
            t_out_beat e;
            if (expected.size() == 0) begin
                report($sformatf("unexpected beat data %02h", d));
                return;
            end
            e = expected.pop_front();
            if (d !== e.data)
                report($sformatf("data %02h, wanted %02h", d, e.data));
            if (lst !== e.last)
                report($sformatf("tlast %b, wanted %b", lst, e.last));
            if (pe !== e.pend)
                report($sformatf("packet end %b, wanted %b", pe, e.pend));
            if (ov !== e.over)
                report($sformatf("oversize %b, wanted %b", ov, e.over));
        endtask
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // in_byte
    logic       s_axis_tuser;   // force_all
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // out_byte
    logic       m_axis_tlast;   // last_of_run
    logic [1:0] m_axis_tuser;   // packet_end, oversize

    tlv_scoreboard sb;
    int send_idle = 0;
    int recv_stall = 0;
    int bytes_sent = 0;

    tlv_change_compactor_unit #(
        .MAX_VALUE_BYTES(MAX_VB),
        .NUM_TYPES(N_TYPES)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    // receiver side
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready = ($urandom_range(99) >= recv_stall);
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser[0],
                                m_axis_tuser[1]);
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit frc);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = b;
        s_axis_tuser = frc;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(b, frc);
        bytes_sent++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // one element; often a repeat of the stored one so that unchanged ones are dropped
    task automatic send_element(input logic [7:0] t, input logic [7:0] len,
                                input bit same, input bit frc);
        logic [7:0] v;
        send_byte(t, frc);
        send_byte(len, frc);
        for (int i = 0; i < len; i++) begin
            if (len <= MAX_VB && same && $urandom_range(19) != 0)
                v = sb.val_store[t][i];
            else
                v = 8'($urandom_range(255));
            send_byte(v, frc && (i == len - 1 || $urandom_range(3) == 0));
        end
    endtask

    task automatic random_packet();
        int n;
        logic [7:0] t;
        logic [7:0] len;
        bit same;
        send_byte(8'($urandom_range(255)), $urandom_range(1) != 0);
        n = $urandom_range(5);
        for (int e = 0; e < n; e++) begin
            t = ($urandom_range(9) == 0) ? 8'($urandom_range(255, 1))
                                         : 8'($urandom_range(8, 1));
            same = $urandom_range(2) != 0;
            case ($urandom_range(19))
                0: len = 8'($urandom_range(70, 63));
                1: len = 8'(MAX_VB);
                2: len = 8'd0;
                default: len = same ? {2'b00, sb.len_store[t]} : 8'($urandom_range(6));
            endcase
            if (same && sb.len_store[t] != len[5:0]) same = 1'b0;
            send_element(t, len, same, $urandom_range(7) == 0);
        end
        send_byte(8'd0, $urandom_range(1) != 0);
    endtask

    initial begin
        int wait_cycles;
        sb = new();
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'd0;
        s_axis_tuser = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed packets: extremes, zero length, oversize, repeats
        send_byte(8'hFF, 1'b0);
        send_element(8'hFF, 8'd2, 0, 1'b0);
        send_element(8'hFF, 8'd2, 1, 1'b0);
        send_element(8'h01, 8'd0, 0, 1'b0);
        send_element(8'h01, 8'd0, 0, 1'b1);
        send_element(8'h02, 8'd3, 0, 1'b1);
        send_element(8'h02, 8'd3, 1, 1'b0);
        send_byte(8'd0, 1'b1);
        send_byte(8'h00, 1'b1);
        send_element(8'h04, 8'd63, 0, 1'b1);
        send_element(8'h05, 8'd62, 0, 1'b0);
        send_element(8'h05, 8'd62, 1, 1'b0);
        send_byte(8'd0, 1'b0);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 81; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 81; end
                default: begin send_idle = 17; recv_stall = 17; end
            endcase
            wait_cycles = bytes_sent + 20;
            while (bytes_sent < wait_cycles) random_packet();
        end

        wait_cycles = 0;
        while (sb.expected.size() != 0 && wait_cycles < 100_000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (100) @(posedge i_clk);
        if (errors == 0 && sb.expected.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[files.f]
sv/tlvc_pkg.sv
sv/tlvc_front.sv
sv/tlvc_back.sv
sv/tlv_change_compactor_unit.sv
bench/tlv_change_compactor_unit_test.sv
